FILE: rtl/tcfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcfe_pkg
// Shared types and codes of the map-tile cache with farthest-slot eviction.
// ----------------------------------------------------------------------------
package tcfe_pkg;

	localparam logic [1:0] STATUS_REJECT = 2'd0;
	localparam logic [1:0] STATUS_HIT    = 2'd1;
	localparam logic [1:0] STATUS_FILL   = 2'd2;
	localparam logic [1:0] STATUS_EVICT  = 2'd3;

	typedef struct packed {
		logic match;
		logic farther;
	} tcfe_cmp_t;

endpackage
`default_nettype wire

FILE: rtl/tcfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcfe_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tcfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

FILE: rtl/tcfe_dist_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcfe_dist_unit
// Shared compare unit: tests one slot for a tag match and works out its
// Manhattan distance from the centre tile against the best so far.
// ----------------------------------------------------------------------------
module tcfe_dist_unit
	import tcfe_pkg::*;
#(
	parameter int COORD_W = 6,
	parameter int DIST_W  = 8
) (
	input  wire logic               entry_valid,
	input  wire logic [COORD_W-1:0] entry_col,
	input  wire logic [COORD_W-1:0] entry_row,
	input  wire logic [COORD_W-1:0] req_col,
	input  wire logic [COORD_W-1:0] req_row,
	input  wire logic [5:0]         center_col,
	input  wire logic [5:0]         center_row,
	input  wire logic [DIST_W-1:0]  best,
	output logic      [DIST_W-1:0]  distance,
	output tcfe_cmp_t               cmp
);

	localparam int EW = DIST_W - 1;

	logic [EW-1:0] col_e;
	logic [EW-1:0] row_e;
	logic [EW-1:0] ccol_e;
	logic [EW-1:0] crow_e;
	logic [EW-1:0] dcol;
	logic [EW-1:0] drow;

	always_comb begin
		col_e  = EW'(entry_col);
		row_e  = EW'(entry_row);
		ccol_e = EW'(center_col);
		crow_e = EW'(center_row);
		dcol   = (col_e >= ccol_e) ? (col_e - ccol_e) : (ccol_e - col_e);
		drow   = (row_e >= crow_e) ? (row_e - crow_e) : (crow_e - row_e);
		distance    = DIST_W'(dcol) + DIST_W'(drow);
		cmp.match   = entry_valid && (entry_col == req_col) && (entry_row == req_row);
		cmp.farther = distance > best;
	end

endmodule
`default_nettype wire

FILE: rtl/tile_cache_farthest_eviction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_cache_farthest_eviction
// Fully associative cache of map-tile slots. A miss fills the lowest free
// slot or, when all are full, evicts the slot farthest from the centre tile.
// ----------------------------------------------------------------------------
//  Channel   Handshake         Payload
//  request   start / busy      tile_x, tile_z, center_x, center_z, has_terrain
//  result    done (strobe)     status, slot, evicted_x, evicted_z
//
//  A rejected request gives its result in the cycle after the transaction.
//  Any other request scans every slot through the shared compare unit, one
//  slot a cycle from the tag RAM; the result shows in the same cycle that
//  busy falls.
//  After reset every slot is free. The receiver cannot stall the block.
// ----------------------------------------------------------------------------
module tile_cache_farthest_eviction
	import tcfe_pkg::*;
#(
	parameter int CACHE_SLOTS = 16,
	parameter int MAP_SIDE    = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic signed [7:0] tile_x,
	input  wire logic signed [7:0] tile_z,
	input  wire logic [5:0]       center_x,
	input  wire logic [5:0]       center_z,
	input  wire logic             has_terrain,
	output logic                  done,
	output logic      [1:0]       status,
	output logic      [3:0]       slot,
	output logic      [5:0]       evicted_x,
	output logic      [5:0]       evicted_z
);

	localparam int SLOT_W  = $clog2(CACHE_SLOTS);
	localparam int COORD_W = (MAP_SIDE > 2) ? $clog2(MAP_SIDE) : 1;
	localparam int EW      = ((COORD_W > 6) ? COORD_W : 6) + 1;
	localparam int DIST_W  = EW + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]             state_q;
	logic                   issue_q;
	logic [SLOT_W-1:0]      cnt_q;
	logic                   rd_vld_s1;
	logic [SLOT_W-1:0]      rd_idx_s1;
	logic [CACHE_SLOTS-1:0] valid_q;
	logic                   hit_q;
	logic [SLOT_W-1:0]      hit_slot_q;
	logic                   free_found_q;
	logic [SLOT_W-1:0]      free_slot_q;
	logic [DIST_W-1:0]      best_q;
	logic [SLOT_W-1:0]      victim_q;
	logic [COORD_W-1:0]     vic_col_q;
	logic [COORD_W-1:0]     vic_row_q;
	logic [COORD_W-1:0]     tx_q;
	logic [COORD_W-1:0]     tz_q;
	logic [5:0]             cx_q;
	logic [5:0]             cz_q;

	logic                   accept;
	logic                   in_map;
	logic                   last_s1;
	logic                   wr_en;
	logic [SLOT_W-1:0]      fill_slot;
	logic [2*COORD_W-1:0]   rd_data;
	logic [COORD_W-1:0]     rd_col;
	logic [COORD_W-1:0]     rd_row;
	logic [DIST_W-1:0]      distance;
	tcfe_cmp_t              cmp;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign in_map    = !tile_x[7] && !tile_z[7] && has_terrain
	                   && ({1'b0, tile_x} < 9'(MAP_SIDE))
	                   && ({1'b0, tile_z} < 9'(MAP_SIDE));
	assign last_s1   = rd_vld_s1 && (rd_idx_s1 == SLOT_W'(CACHE_SLOTS - 1));
	assign fill_slot = free_found_q ? free_slot_q : victim_q;
	assign wr_en     = (state_q == S_FIN) && !hit_q;
	assign rd_col    = rd_data[2*COORD_W-1:COORD_W];
	assign rd_row    = rd_data[COORD_W-1:0];

	tcfe_ram #(
		.WIDTH (2 * COORD_W),
		.DEPTH (CACHE_SLOTS)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_slot),
		.wr_data ({tx_q, tz_q}),
		.rd_addr (cnt_q),
		.rd_data (rd_data)
	);

	tcfe_dist_unit #(
		.COORD_W (COORD_W),
		.DIST_W  (DIST_W)
	) u_dist (
		.entry_valid (valid_q[rd_idx_s1]),
		.entry_col   (rd_col),
		.entry_row   (rd_row),
		.req_col     (tx_q),
		.req_row     (tz_q),
		.center_col  (cx_q),
		.center_row  (cz_q),
		.best        (best_q),
		.distance    (distance),
		.cmp         (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issue_q      <= 1'b0;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			valid_q      <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			done         <= 1'b0;
		end else begin
			done      <= 1'b0;
			rd_vld_s1 <= issue_q;
			rd_idx_s1 <= cnt_q;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						cnt_q        <= '0;
						if (in_map) begin
							issue_q <= 1'b1;
							state_q <= S_SCAN;
						end else begin
							done <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						if (cnt_q == SLOT_W'(CACHE_SLOTS - 1)) begin
							issue_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (rd_vld_s1) begin
						if (cmp.match) begin
							hit_q <= 1'b1;
						end
						if (!valid_q[rd_idx_s1]) begin
							free_found_q <= 1'b1;
						end
					end
					if (last_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!hit_q) begin
						valid_q[fill_slot] <= 1'b1;
					end
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_q     <= tile_x[COORD_W-1:0];
			tz_q     <= tile_z[COORD_W-1:0];
			cx_q     <= center_x;
			cz_q     <= center_z;
			best_q   <= '0;
			victim_q <= '0;
			if (!in_map) begin
				status    <= STATUS_REJECT;
				slot      <= '0;
				evicted_x <= '0;
				evicted_z <= '0;
			end
		end
		if (state_q == S_SCAN && rd_vld_s1) begin
			if (cmp.match && !hit_q) begin
				hit_slot_q <= rd_idx_s1;
			end
			if (!valid_q[rd_idx_s1] && !free_found_q) begin
				free_slot_q <= rd_idx_s1;
			end
			if (rd_idx_s1 == '0 || cmp.farther) begin
				best_q    <= distance;
				victim_q  <= rd_idx_s1;
				vic_col_q <= rd_col;
				vic_row_q <= rd_row;
			end
		end
		if (state_q == S_FIN) begin
			if (hit_q) begin
				status    <= STATUS_HIT;
				slot      <= 4'(hit_slot_q);
				evicted_x <= '0;
				evicted_z <= '0;
			end else if (free_found_q) begin
				status    <= STATUS_FILL;
				slot      <= 4'(free_slot_q);
				evicted_x <= '0;
				evicted_z <= '0;
			end else begin
				status    <= STATUS_EVICT;
				slot      <= 4'(victim_q);
				evicted_x <= 6'(vic_col_q);
				evicted_z <= 6'(vic_row_q);
			end
		end
	end

endmodule
`default_nettype wire
